FILE: rtl/frgcd_pkg.sv
// ----------------------------------------------------------------------------
// frgcd_pkg: shared types and constants of the fraction reducer
// Value width, queue sizing and the job word passed from front to back.
// ----------------------------------------------------------------------------
package frgcd_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int SHIFT_W     = $clog2(VALUE_WIDTH);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    typedef logic [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        t_value numerator;
        t_value denominator;
        logic   zero;
    } t_job;

endpackage

FILE: rtl/frgcd_in_if.sv
// ----------------------------------------------------------------------------
// frgcd_in_if: fraction input channel
// Valid/ready channel carrying one numerator and denominator per beat.
// ----------------------------------------------------------------------------
interface frgcd_in_if;
    import frgcd_pkg::*;

    logic   valid;
    logic   ready;
    t_value numerator;
    t_value denominator;

    modport source (output valid, output numerator, output denominator, input ready);
    modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

FILE: rtl/frgcd_out_if.sv
// ----------------------------------------------------------------------------
// frgcd_out_if: reduced fraction output channel
// Valid/ready channel carrying the reduced fraction and its divisor.
// ----------------------------------------------------------------------------
interface frgcd_out_if;
    import frgcd_pkg::*;

    logic   valid;
    logic   ready;
    t_value reduced_numerator;
    t_value reduced_denominator;
    t_value common_divisor;
    logic   zero_error;

    modport source (output valid, output reduced_numerator, output reduced_denominator,
                    output common_divisor, output zero_error, input ready);
    modport sink   (input valid, input reduced_numerator, input reduced_denominator,
                    input common_divisor, input zero_error, output ready);
endinterface

FILE: rtl/frgcd_front.sv
// ----------------------------------------------------------------------------
// frgcd_front: input stage
// Registers each input beat and flags a zero operand before queueing it.
// ----------------------------------------------------------------------------
module frgcd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    frgcd_in_if.sink         i_frac,
    output logic             o_job_valid,
    input  logic             i_job_ready,
    output frgcd_pkg::t_job  o_job
);
    import frgcd_pkg::*;

    logic r_valid;
    t_job r_job;
    logic accept;

    assign i_frac.ready = !r_valid || i_job_ready;
    assign accept       = i_frac.valid && i_frac.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.numerator   <= i_frac.numerator;
            r_job.denominator <= i_frac.denominator;
            r_job.zero        <= (i_frac.numerator == '0) || (i_frac.denominator == '0);
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;
endmodule

FILE: rtl/frgcd_queue.sv
// ----------------------------------------------------------------------------
// frgcd_queue: job queue
// Short FIFO between the input stage and the GCD engine.
// ----------------------------------------------------------------------------
module frgcd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  frgcd_pkg::t_job  i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output frgcd_pkg::t_job  o_job
);
    import frgcd_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_ready = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] nxt;
        if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end
endmodule

FILE: rtl/frgcd_back.sv
// ----------------------------------------------------------------------------
// frgcd_back: GCD and divide engine
// Binary GCD one step a cycle, then both values divided by the GCD bit-serially.
// ----------------------------------------------------------------------------
module frgcd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_job_valid,
    output logic             o_job_ready,
    input  frgcd_pkg::t_job  i_job,
    frgcd_out_if.source      o_frac
);
    import frgcd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GCD  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         r_state, n_state;
    t_value             r_a, n_a;
    t_value             r_b, n_b;
    logic [SHIFT_W-1:0] r_k, n_k;
    t_value             r_div, n_div;
    t_value             r_qn, n_qn;
    t_value             r_qd, n_qd;
    t_value             r_rem_n, n_rem_n;
    t_value             r_rem_d, n_rem_d;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_zero, n_zero;

    logic               load;
    t_value             diff_ab;
    t_value             diff_ba;
    logic [VALUE_WIDTH:0] trial_n;
    logic [VALUE_WIDTH:0] trial_d;
    logic               fit_n;
    logic               fit_d;

    assign o_job_ready = (r_state == ST_IDLE);
    assign load        = i_job_valid && o_job_ready;

    assign diff_ab = r_a - r_b;
    assign diff_ba = r_b - r_a;

    // shift the next dividend bit into each partial remainder
    assign trial_n = {r_rem_n, r_qn[VALUE_WIDTH-1]};
    assign trial_d = {r_rem_d, r_qd[VALUE_WIDTH-1]};
    assign fit_n   = (trial_n >= {1'b0, r_div});
    assign fit_d   = (trial_d >= {1'b0, r_div});

    always_comb begin
        n_state = r_state;
        n_a     = r_a;
        n_b     = r_b;
        n_k     = r_k;
        n_div   = r_div;
        n_qn    = r_qn;
        n_qd    = r_qd;
        n_rem_n = r_rem_n;
        n_rem_d = r_rem_d;
        n_step  = r_step;
        n_zero  = r_zero;
        case (r_state)
            ST_IDLE: begin
                if (load) begin
                    n_a     = i_job.numerator;
                    n_b     = i_job.denominator;
                    n_qn    = i_job.numerator;
                    n_qd    = i_job.denominator;
                    n_k     = '0;
                    n_div   = '0;
                    n_rem_n = '0;
                    n_rem_d = '0;
                    n_zero  = i_job.zero;
                    // zero operand: pass the fraction straight through
                    n_state = i_job.zero ? ST_DONE : ST_GCD;
                end
            end
            ST_GCD: begin
                if (r_a == '0 || r_b == '0) begin
                    n_div   = (r_a | r_b) << r_k;
                    n_step  = '0;
                    n_state = ST_DIV;
                end else if (!r_a[0] && !r_b[0]) begin
                    n_a = r_a >> 1;
                    n_b = r_b >> 1;
                    n_k = r_k + 1'b1;
                end else if (!r_a[0]) begin
                    n_a = r_a >> 1;
                end else if (!r_b[0]) begin
                    n_b = r_b >> 1;
                end else if (r_a >= r_b) begin
                    n_a = diff_ab >> 1;
                end else begin
                    n_b = diff_ba >> 1;
                end
            end
            ST_DIV: begin
                n_qn    = {r_qn[VALUE_WIDTH-2:0], fit_n};
                n_qd    = {r_qd[VALUE_WIDTH-2:0], fit_d};
                n_rem_n = fit_n ? VALUE_WIDTH'(trial_n - {1'b0, r_div})
                                : VALUE_WIDTH'(trial_n);
                n_rem_d = fit_d ? VALUE_WIDTH'(trial_d - {1'b0, r_div})
                                : VALUE_WIDTH'(trial_d);
                n_step  = r_step + 1'b1;
                if (r_step == STEP_W'(VALUE_WIDTH - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the result until the beat is taken
                if (o_frac.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
        r_div   <= n_div;
        r_qn    <= n_qn;
        r_qd    <= n_qd;
        r_rem_n <= n_rem_n;
        r_rem_d <= n_rem_d;
        r_step  <= n_step;
        r_zero  <= n_zero;
    end

    assign o_frac.valid               = (r_state == ST_DONE);
    assign o_frac.reduced_numerator   = r_qn;
    assign o_frac.reduced_denominator = r_qd;
    assign o_frac.common_divisor      = r_div;
    assign o_frac.zero_error          = r_zero;

    a_gcd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_GCD) |-> (r_a != '0 || r_b != '0))
        else $error("gcd operands both zero");

    a_exact_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frac.valid && !o_frac.zero_error) |->
            (r_rem_n == '0 && r_rem_d == '0 && r_div != '0))
        else $error("division left a remainder");

    a_zero_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frac.valid && o_frac.zero_error) |->
            (o_frac.common_divisor == '0 &&
             (o_frac.reduced_numerator == '0 || o_frac.reduced_denominator == '0)))
        else $error("zero error without a zero operand");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |=> (r_state == ST_DIV || r_state == ST_DONE))
        else $error("divide phase left early");
endmodule

FILE: rtl/fraction_reducer_gcd_unit.sv
// ----------------------------------------------------------------------------
// fraction_reducer_gcd_unit: reduces a fraction to lowest terms
// GCD steps: binary GCD engine, one shift or subtract a cycle, at most 2*VALUE_WIDTH.
// Divide: both values divided by the GCD in parallel, one quotient bit a cycle.
// Throughput: one fraction per engine pass; a two-entry queue takes new beats meanwhile.
// Zero operand: skips the GCD and divide phases and passes through with the error flag set.
// Reset: synchronous active-low; clears control state and empties the queue.
// ----------------------------------------------------------------------------
module fraction_reducer_gcd_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    frgcd_in_if.sink    i_frac,
    frgcd_out_if.source o_frac
);
    import frgcd_pkg::*;

    logic front_valid;
    logic front_ready;
    t_job front_job;
    logic queue_valid;
    logic queue_ready;
    t_job queue_job;

    frgcd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frac      (i_frac),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready),
        .o_job       (front_job)
    );

    frgcd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_job   (front_job),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_job   (queue_job)
    );

    frgcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (queue_valid),
        .o_job_ready (queue_ready),
        .i_job       (queue_job),
        .o_frac      (o_frac)
    );
endmodule
